[rtl/core/mcrr_pkg.sv]
`default_nettype none
package mcrr_pkg;

    localparam logic [2:0] OP_DRIVE      = 3'd0;
    localparam logic [2:0] OP_START_REC  = 3'd1;
    localparam logic [2:0] OP_START_PLAY = 3'd2;
    localparam logic [2:0] OP_STOP_ANY   = 3'd3;
    localparam logic [2:0] OP_STOP_REC   = 3'd4;
    localparam logic [2:0] OP_STOP_PLAY  = 3'd5;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_SPIN  = 2'd1;
    localparam logic [1:0] ACT_BRAKE = 2'd2;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REC  = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;

    localparam logic [1:0] UNIT_PERCENT = 2'd0;
    localparam logic [1:0] UNIT_INVALID = 2'd3;

    localparam int TIME_BITS  = 32;
    localparam int SPEED_BITS = 16;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctrl_cmd;

endpackage
`default_nettype wire

[rtl/core/mcrr_ctrl.sv]
`default_nettype none
module mcrr_ctrl
    import mcrr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    output logic           o_busy,
    output t_ctrl_cmd      o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_busy        = (r_state == S_EXEC);
        o_cmd.capture = i_start && (r_state == S_IDLE);
        o_cmd.execute = (r_state == S_EXEC);
        n_state       = o_cmd.capture ? S_EXEC : S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> !o_busy)
        else $error("busy held longer than one cycle");

    a_exec_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |-> $past(o_cmd.capture))
        else $error("execute without preceding capture");

endmodule
`default_nettype wire

[rtl/core/mcrr_datapath.sv]
`default_nettype none
module mcrr_datapath
    import mcrr_pkg::*;
#(
    parameter int ENTRY_DEPTH   = 1024,
    parameter int VELOCITY_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_ctrl_cmd                    i_cmd,
    input  wire logic [2:0]                   i_op,
    input  wire logic [TIME_BITS-1:0]         i_now_ms,
    input  wire logic                         i_reverse,
    input  wire logic signed [SPEED_BITS-1:0] i_speed,
    input  wire logic [1:0]                   i_unit_code,
    output logic                              o_strobe,
    output logic [1:0]                        o_drive_action,
    output logic signed [SPEED_BITS-1:0]      o_drive_velocity,
    output logic [1:0]                        o_drive_unit,
    output logic [1:0]                        o_mode,
    output logic                              o_playback_done,
    output logic                              o_overflow
);

    localparam int VB = VELOCITY_BITS;
    localparam int AW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int CW = $clog2(ENTRY_DEPTH + 1);
    localparam int W  = ((VB > SPEED_BITS) ? VB : SPEED_BITS) + 1;
    localparam int EW = TIME_BITS + VB + 2;
    localparam logic signed [W-1:0] VMAX = {{(W-VB+1){1'b0}}, {(VB-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = ~VMAX;
    localparam logic [CW-1:0] DEPTH_C = CW'(ENTRY_DEPTH);

    logic [EW-1:0] mem [ENTRY_DEPTH];

    // captured transaction
    logic [2:0]            r_op;
    logic [TIME_BITS-1:0]  r_now;
    logic signed [VB-1:0]  r_vel;
    logic [1:0]            r_unit;
    logic [EW-1:0]         r_rd;

    // block state
    logic [1:0]            r_mode;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_ptr;
    logic [TIME_BITS-1:0]  r_start_time;
    logic [TIME_BITS-1:0]  r_last_time;

    logic [1:0]            n_mode;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         n_ptr;
    logic [TIME_BITS-1:0]  n_start_time;
    logic [TIME_BITS-1:0]  n_last_time;
    logic [1:0]            n_action;
    logic signed [VB-1:0]  n_vel;
    logic [1:0]            n_unit;
    logic                  n_ovf;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [EW-1:0]         mem_wd;

    logic signed [W-1:0]   spd_w;
    logic signed [W-1:0]   spd_c;
    logic signed [W-1:0]   spd_n;
    logic signed [W-1:0]   spd_f;
    logic [1:0]            unit_in;

    logic [TIME_BITS-1:0]  rd_time;
    logic signed [VB-1:0]  rd_vel;
    logic [1:0]            rd_unit;
    logic [TIME_BITS-1:0]  due_time;
    logic signed [W-1:0]   vel_out;

    // input velocity: clamp, optional negate, clamp again
    always_comb begin
        spd_w = W'(i_speed);
        if (spd_w > VMAX) begin
            spd_c = VMAX;
        end else if (spd_w < VMIN) begin
            spd_c = VMIN;
        end else begin
            spd_c = spd_w;
        end
        spd_n = -spd_c;
        if (!i_reverse) begin
            spd_f = spd_c;
        end else if (spd_n > VMAX) begin
            spd_f = VMAX;
        end else begin
            spd_f = spd_n;
        end
        unit_in = (i_unit_code == UNIT_INVALID) ? UNIT_PERCENT : i_unit_code;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_now  <= i_now_ms;
            r_vel  <= spd_f[VB-1:0];
            r_unit <= unit_in;
            r_rd   <= mem[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_comb begin
        rd_time  = r_rd[EW-1 -: TIME_BITS];
        rd_vel   = r_rd[VB+1:2];
        rd_unit  = r_rd[1:0];
        due_time = r_start_time + rd_time;

        n_mode       = r_mode;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_start_time = r_start_time;
        n_last_time  = r_last_time;
        n_action     = ACT_NONE;
        n_vel        = '0;
        n_unit       = UNIT_PERCENT;
        n_ovf        = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = r_count[AW-1:0];
        mem_wd       = {r_now - r_start_time, r_vel, r_unit};

        unique case (r_op)
            OP_DRIVE: begin
                if (r_mode == MODE_REC) begin
                    if (r_now > r_last_time) begin
                        n_action    = ACT_SPIN;
                        n_vel       = r_vel;
                        n_unit      = r_unit;
                        n_last_time = r_now;
                        if (r_count < DEPTH_C) begin
                            mem_we  = i_cmd.execute;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end else if (r_mode == MODE_PLAY) begin
                    if (r_ptr >= r_count) begin
                        n_action = ACT_BRAKE;
                    end else if (r_now >= due_time) begin
                        n_action = ACT_SPIN;
                        n_vel    = rd_vel;
                        n_unit   = rd_unit;
                        n_ptr    = r_ptr + CW'(1);
                    end
                end else begin
                    n_action = ACT_SPIN;
                    n_vel    = r_vel;
                    n_unit   = r_unit;
                end
            end
            OP_START_REC: begin
                n_start_time = r_now;
                n_last_time  = r_now;
                n_count      = CW'(1);
                n_mode       = MODE_REC;
                mem_we       = i_cmd.execute;
                mem_wa       = '0;
                mem_wd       = '0;
            end
            OP_START_PLAY: begin
                n_ptr        = '0;
                n_start_time = r_now;
                n_mode       = MODE_PLAY;
            end
            OP_STOP_ANY: begin
                n_mode = MODE_IDLE;
            end
            OP_STOP_REC: begin
                if (r_mode == MODE_REC) begin
                    n_mode = MODE_IDLE;
                end
            end
            OP_STOP_PLAY: begin
                if (r_mode == MODE_PLAY) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
            end
        endcase

        vel_out = W'(n_vel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_count      <= '0;
            r_ptr        <= '0;
            r_start_time <= '0;
            r_last_time  <= '0;
            o_strobe     <= 1'b0;
        end else begin
            o_strobe <= i_cmd.execute;
            if (i_cmd.execute) begin
                r_mode       <= n_mode;
                r_count      <= n_count;
                r_ptr        <= n_ptr;
                r_start_time <= n_start_time;
                r_last_time  <= n_last_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            o_drive_action   <= n_action;
            o_drive_velocity <= vel_out[SPEED_BITS-1:0];
            o_drive_unit     <= n_unit;
            o_mode           <= n_mode;
            o_playback_done  <= (n_ptr >= n_count);
            o_overflow       <= n_ovf;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond store depth");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_drive_action != ACT_SPIN) |->
        (o_drive_velocity == '0 && o_drive_unit == UNIT_PERCENT))
        else $error("velocity or unit set without motor update");

    a_overflow_recording: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_overflow) |->
        (o_drive_action == ACT_SPIN && o_mode == MODE_REC && r_count == DEPTH_C))
        else $error("overflow outside a full recording");

endmodule
`default_nettype wire

[rtl/core/motor_command_record_replay_unit.sv]
`default_nettype none
// Records timestamped motor velocity commands and replays them. A transaction is
// accepted when start is high while busy is low; busy is then high for exactly
// one cycle, and no new transaction is taken while it is high. The result
// appears on the o_ result ports for one cycle with o_strobe high, and cannot
// be stalled. At the accepting edge the transaction is captured and the entry
// store is read into a register; decode and state update then follow, with at
// most one store write, and the result is registered onto the o_ ports.
// No clearing pass after reset.
module motor_command_record_replay_unit
    import mcrr_pkg::*;
#(
    parameter int ENTRY_DEPTH   = 1024,
    parameter int VELOCITY_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [2:0]                   i_op,
    input  wire logic [TIME_BITS-1:0]         i_now_ms,
    input  wire logic                         i_reverse,
    input  wire logic signed [SPEED_BITS-1:0] i_speed,
    input  wire logic [1:0]                   i_unit_code,
    output logic                              o_strobe,
    output logic [1:0]                        o_drive_action,
    output logic signed [SPEED_BITS-1:0]      o_drive_velocity,
    output logic [1:0]                        o_drive_unit,
    output logic [1:0]                        o_mode,
    output logic                              o_playback_done,
    output logic                              o_overflow
);

    t_ctrl_cmd cmd;

    mcrr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    mcrr_datapath #(
        .ENTRY_DEPTH   (ENTRY_DEPTH),
        .VELOCITY_BITS (VELOCITY_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_op             (i_op),
        .i_now_ms         (i_now_ms),
        .i_reverse        (i_reverse),
        .i_speed          (i_speed),
        .i_unit_code      (i_unit_code),
        .o_strobe         (o_strobe),
        .o_drive_action   (o_drive_action),
        .o_drive_velocity (o_drive_velocity),
        .o_drive_unit     (o_drive_unit),
        .o_mode           (o_mode),
        .o_playback_done  (o_playback_done),
        .o_overflow       (o_overflow)
    );

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
    import mcrr_pkg::*;

    localparam int ENTRY_DEPTH    = 1024;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 1900;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [1:0]        action;
        logic signed [15:0] velocity;
        logic [1:0]        unit;
        logic [1:0]        mode;
        logic              done;
        logic              ovf;
    } drive_result_t;

    typedef struct {
        logic [31:0]        rel_time;
        logic signed [15:0] velocity;
        logic [1:0]         unit;
    } replay_entry_t;

    class replay_scoreboard;
        logic [1:0]    cur_mode;
        replay_entry_t entries[ENTRY_DEPTH];
        int            entry_count;
        int            replay_pointer;
        logic [31:0]   start_ms;
        logic [31:0]   last_rec_ms;
        drive_result_t expected_drives[$];
        int            mismatches;

        function new();
            cur_mode       = MODE_IDLE;
            entry_count    = 0;
            replay_pointer = 0;
            start_ms       = '0;
            last_rec_ms    = '0;
            mismatches     = 0;
        endfunction

        function void note_command(logic [2:0] op, logic [31:0] now, logic rev,
                                   logic signed [15:0] spd, logic [1:0] unit_code);
            drive_result_t r;
            logic [1:0]    u;
            int            v;
            logic [31:0]   due_ms;
            r = '0;
            u = (unit_code == UNIT_INVALID) ? UNIT_PERCENT : unit_code;
            v = spd;
            if (rev) begin
                v = (v == -32768) ? 32767 : -v;
            end
            case (op)
                OP_DRIVE: begin
                    if (cur_mode == MODE_REC) begin
                        if (now > last_rec_ms) begin
                            r.action   = ACT_SPIN;
                            r.velocity = v[15:0];
                            r.unit     = u;
                            if (entry_count < ENTRY_DEPTH) begin
                                entries[entry_count].rel_time = now - start_ms;
                                entries[entry_count].velocity = v[15:0];
                                entries[entry_count].unit     = u;
                                entry_count++;
                            end else begin
                                r.ovf = 1'b1;
                            end
                            last_rec_ms = now;
                        end
                    end else if (cur_mode == MODE_PLAY) begin
                        if (replay_pointer >= entry_count) begin
                            r.action = ACT_BRAKE;
                        end else begin
                            due_ms = start_ms + entries[replay_pointer].rel_time;
                            if (now >= due_ms) begin
                                r.action   = ACT_SPIN;
                                r.velocity = entries[replay_pointer].velocity;
                                r.unit     = entries[replay_pointer].unit;
                                replay_pointer++;
                            end
                        end
                    end else begin
                        r.action   = ACT_SPIN;
                        r.velocity = v[15:0];
                        r.unit     = u;
                    end
                end
                OP_START_REC: begin
                    start_ms             = now;
                    last_rec_ms          = now;
                    entries[0].rel_time  = '0;
                    entries[0].velocity  = '0;
                    entries[0].unit      = UNIT_PERCENT;
                    entry_count          = 1;
                    cur_mode             = MODE_REC;
                end
                OP_START_PLAY: begin
                    replay_pointer = 0;
                    start_ms       = now;
                    cur_mode       = MODE_PLAY;
                end
                OP_STOP_ANY: cur_mode = MODE_IDLE;
                OP_STOP_REC: begin
                    if (cur_mode == MODE_REC) cur_mode = MODE_IDLE;
                end
                OP_STOP_PLAY: begin
                    if (cur_mode == MODE_PLAY) cur_mode = MODE_IDLE;
                end
                default: ;
            endcase
            r.mode = cur_mode;
            r.done = (replay_pointer >= entry_count);
            expected_drives.insert(expected_drives.size(), r);
        endfunction

        function void check_drive(drive_result_t got);
            drive_result_t want;
            if (expected_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected drive result: act=%0d vel=%0d unit=%0d mode=%0d done=%0b ovf=%0b",
                             got.action, got.velocity, got.unit, got.mode, got.done, got.ovf);
                end
                return;
            end
            want = expected_drives.pop_front();
            if (got.action !== want.action || got.velocity !== want.velocity ||
                got.unit !== want.unit || got.mode !== want.mode ||
                got.done !== want.done || got.ovf !== want.ovf) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("drive result mismatch at %0t", $realtime);
                    $display("  exp: act=%0d vel=%0d unit=%0d mode=%0d done=%0b ovf=%0b",
                             want.action, want.velocity, want.unit, want.mode, want.done,
                             want.ovf);
                    $display("  got: act=%0d vel=%0d unit=%0d mode=%0d done=%0b ovf=%0b",
                             got.action, got.velocity, got.unit, got.mode, got.done, got.ovf);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_op;
    logic [31:0]        i_now_ms;
    logic               i_reverse;
    logic signed [15:0] i_speed;
    logic [1:0]         i_unit_code;
    logic               o_strobe;
    logic [1:0]         o_drive_action;
    logic signed [15:0] o_drive_velocity;
    logic [1:0]         o_drive_unit;
    logic [1:0]         o_mode;
    logic               o_playback_done;
    logic               o_overflow;

    replay_scoreboard sb;
    int               items_sent = 0;
    int               idle_pct = 0;
    int               quiet_cycles = 0;
    logic [31:0]      clock_ms = 32'd0;
    logic             store_filled = 1'b0;

    motor_command_record_replay_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_now_ms         (i_now_ms),
        .i_reverse        (i_reverse),
        .i_speed          (i_speed),
        .i_unit_code      (i_unit_code),
        .o_strobe         (o_strobe),
        .o_drive_action   (o_drive_action),
        .o_drive_velocity (o_drive_velocity),
        .o_drive_unit     (o_drive_unit),
        .o_mode           (o_mode),
        .o_playback_done  (o_playback_done),
        .o_overflow       (o_overflow)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            sb.check_drive({o_drive_action, o_drive_velocity, o_drive_unit, o_mode,
                            o_playback_done, o_overflow});
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && busy === 1'b0) || o_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [15:0] pick_speed();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_command(input logic [2:0] op, input logic [31:0] now,
                                input logic rev, input logic signed [15:0] spd,
                                input logic [1:0] unit_code);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_op        <= op;
        i_now_ms    <= now;
        i_reverse   <= rev;
        i_speed     <= spd;
        i_unit_code <= unit_code;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(op, now, rev, spd, unit_code);
        items_sent++;
        // sweep idle phases: none, sender 80%, none, sender 31%
        case ((items_sent / 150) % 4)
            1: idle_pct = 80;
            3: idle_pct = 31;
            default: idle_pct = 0;
        endcase
    endtask

    task automatic send_op(input logic [2:0] op, input logic [31:0] now);
        send_command(op, now, 1'($urandom), pick_speed(), 2'($urandom));
    endtask

    task automatic drive_at(input logic [31:0] now);
        send_op(OP_DRIVE, now);
    endtask

    task automatic send_stray(input logic [2:0] stray);
        case ($urandom_range(0, 2))
            0: send_op(stray, clock_ms);
            1: send_op(OP_UNUSED_6, clock_ms);
            default: send_op(OP_UNUSED_7, clock_ms);
        endcase
    endtask

    task automatic record_session(input int n);
        int r;
        clock_ms += $urandom_range(0, 50);
        send_op(OP_START_REC, clock_ms);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                drive_at(clock_ms);
            end else if (r < 6) begin
                drive_at(clock_ms - $urandom_range(1, 2000));
            end else if (r < 9) begin
                send_stray(OP_STOP_PLAY);
            end else begin
                clock_ms += $urandom_range(1, 40);
                drive_at(clock_ms);
            end
        end
        send_op($urandom_range(0, 1) ? OP_STOP_REC : OP_STOP_ANY, clock_ms);
    endtask

    task automatic playback_session();
        int steps;
        int r;
        steps = 0;
        clock_ms += $urandom_range(0, 50);
        send_op(OP_START_PLAY, clock_ms);
        while (steps < 120) begin
            steps++;
            r = $urandom_range(0, 99);
            if ((sb.replay_pointer >= sb.entry_count && r < 30) || r == 99) break;
            clock_ms += $urandom_range(0, 30);
            if (r < 3) begin
                send_stray(OP_STOP_REC);
            end else begin
                drive_at(clock_ms);
            end
        end
        send_op($urandom_range(0, 1) ? OP_STOP_PLAY : OP_STOP_ANY, clock_ms);
    endtask

    initial begin
        sb          = new();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_op        <= OP_DRIVE;
        i_now_ms    <= '0;
        i_reverse   <= 1'b0;
        i_speed     <= '0;
        i_unit_code <= UNIT_PERCENT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through, saturation, unit three, unused and misplaced stops
        send_command(OP_DRIVE, 32'd10, 1'b0, 16'sd32767, 2'd1);
        send_command(OP_DRIVE, 32'd11, 1'b1, -16'sd32768, 2'd2);
        send_command(OP_DRIVE, 32'd12, 1'b0, -16'sd32768, UNIT_INVALID);
        send_command(OP_DRIVE, 32'hFFFF_FFFF, 1'b1, 16'sd0, UNIT_PERCENT);
        send_command(OP_UNUSED_6, 32'd20, 1'b1, -16'sd1, UNIT_INVALID);
        send_command(OP_UNUSED_7, 32'd21, 1'b0, 16'sd5, 2'd1);
        send_command(OP_STOP_REC, 32'd22, 1'b0, 16'sd5, 2'd1);
        send_command(OP_STOP_PLAY, 32'd23, 1'b0, 16'sd5, 2'd1);
        // playback with empty store brakes
        send_command(OP_START_PLAY, 32'd100, 1'b0, 16'sd1, 2'd1);
        send_command(OP_DRIVE, 32'd200, 1'b0, 16'sd9, 2'd1);
        send_command(OP_STOP_PLAY, 32'd201, 1'b0, 16'sd9, 2'd1);
        // record with equal and late times
        send_command(OP_START_REC, 32'd1000, 1'b0, 16'sd3, 2'd2);
        send_command(OP_DRIVE, 32'd1000, 1'b0, 16'sd4, 2'd1);
        send_command(OP_DRIVE, 32'd999, 1'b0, 16'sd4, 2'd1);
        send_command(OP_DRIVE, 32'd1010, 1'b1, 16'sd5, 2'd2);
        send_command(OP_DRIVE, 32'd1020, 1'b0, -16'sd7, UNIT_INVALID);
        send_command(OP_STOP_PLAY, 32'd1021, 1'b0, 16'sd0, 2'd0);
        send_command(OP_STOP_REC, 32'd1022, 1'b0, 16'sd0, 2'd0);
        // replay: due, not yet due, due, due, exhausted
        send_command(OP_START_PLAY, 32'd5000, 1'b0, 16'sd0, 2'd0);
        send_command(OP_DRIVE, 32'd5000, 1'b0, 16'sd1, 2'd1);
        send_command(OP_DRIVE, 32'd5005, 1'b0, 16'sd1, 2'd1);
        send_command(OP_DRIVE, 32'd5010, 1'b0, 16'sd1, 2'd1);
        send_command(OP_DRIVE, 32'd5030, 1'b0, 16'sd1, 2'd1);
        send_command(OP_DRIVE, 32'd5031, 1'b0, 16'sd1, 2'd1);
        send_command(OP_STOP_ANY, 32'd5032, 1'b0, 16'sd1, 2'd1);

        clock_ms = 32'd6000;
        while (items_sent < TARGET_ITEMS) begin
            if (!store_filled && items_sent > 400) begin
                // fill the store past its depth
                store_filled = 1'b1;
                record_session(1200);
                playback_session();
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        record_session($urandom_range(1, 40));
                        if ($urandom_range(0, 9) < 7) playback_session();
                    end
                    4, 5, 6: playback_session();
                    7: repeat ($urandom_range(1, 8)) begin
                        clock_ms += $urandom_range(0, 100);
                        drive_at(clock_ms);
                    end
                    8: repeat ($urandom_range(1, 6)) begin
                        send_command(3'($urandom), $urandom, 1'($urandom), 16'($urandom),
                                     2'($urandom));
                    end
                    default: begin
                        clock_ms = $urandom_range(0, 1)
                                 ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 600);
                    end
                endcase
            end
        end
        start <= 1'b0;

        while (sb.expected_drives.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_drives.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
